// ===== hw/rtl/ppdr_pkg.sv =====
// Shared types, constants and helpers for the palette pixel dirty-rect block.
package ppdr_pkg;

  localparam int SUBPIXEL_SCALE_DEF  = 4;
  localparam int MAX_DIMENSION_DEF   = 8192;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int FIFO_DEPTH          = 4;

  localparam int DIM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 14'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd200;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_PIXEL     = 2'd1,
    OP_SAMPLE    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_EXPAND_SIX_BIT = 3'd2,
    CFG_COMPARE_ENABLE = 3'd3,
    CFG_DETAIL_ENABLE  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_RECT  = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             expand_six_bit;
    logic             compare_enable;
    logic             detail_enable;
  } cfg_t;

  // one finished pixel color handed from front to back
  typedef struct packed {
    logic [23:0] color;
    logic [23:0] prev;
  } task_t;

  typedef struct packed {
    result_kind_e     kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             changed;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
    logic             empty;
    logic             last;
  } res_t;

  // x mod p for 16 <= p <= 256, restoring compare-subtract in four steps
  function automatic logic [7:0] slot_mod(logic [7:0] x, int unsigned p);
    logic [11:0] r;
    logic [11:0] step;
    r = {4'd0, x};
    for (int k = 3; k >= 0; k--) begin
      step = 12'(p << k);
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[7:0];
  endfunction

  // VGA 6-bit to 8-bit component expansion
  function automatic logic [7:0] expand6(logic [7:0] c, logic en);
    return en ? {c[7:2], c[7:6]} : c;
  endfunction

endpackage

// ===== hw/rtl/ppdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ppdr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ppdr_fifo.sv =====
// Small queue of finished pixel colors between front and back.
module ppdr_fifo #(
  parameter int DEPTH = ppdr_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppdr_pkg::task_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ppdr_pkg::task_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppdr_pkg::task_t      mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/ppdr_front.sv =====
// Front end: accepts beats, writes and reads the palette, averages tiles.
module ppdr_front #(
  parameter int SUBPIXEL_SCALE  = ppdr_pkg::SUBPIXEL_SCALE_DEF,
  parameter int PALETTE_ENTRIES = ppdr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ppdr_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [7:0]      palette_slot_i,
  input  logic [7:0]      red_in_i,
  input  logic [7:0]      green_in_i,
  input  logic [7:0]      blue_in_i,
  input  logic [7:0]      color_index_i,
  input  logic [23:0]     previous_rgb_i,
  output logic            push_o,
  output ppdr_pkg::task_t push_data_o,
  input  logic            full_i
);

  localparam int AW     = $clog2(PALETTE_ENTRIES);
  localparam int TOTAL  = SUBPIXEL_SCALE * SUBPIXEL_SCALE;
  localparam int HALF   = TOTAL / 2;
  localparam int LOG_T  = $clog2(TOTAL);
  localparam int SUM_W  = 8 + 2 * $clog2(SUBPIXEL_SCALE);
  localparam int CNT_W  = $clog2(TOTAL + 1);
  // exact reciprocal for sums below 2**SUM_W
  localparam int SHIFT   = SUM_W + LOG_T;
  localparam int RECIP   = ((1 << SHIFT) + TOTAL - 1) / TOTAL;
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic              advance;
  logic              accept;
  logic              pal_wr;
  logic              pal_rd;
  ppdr_pkg::op_e     op;
  logic [23:0]       rdata;
  logic [7:0]        wr_slot;
  logic [7:0]        rd_slot;

  // stage 1: palette data arrives
  logic              s1_valid_q;
  logic              s1_tile_q;
  logic [23:0]       s1_prev_q;
  // tile accumulator
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic [SUM_W-1:0]  sum_r_d, sum_g_d, sum_b_d;
  // stage 2: divide and push
  logic              s2_valid_q, s2_valid_d;
  logic              s2_tile_q, s2_tile_d;
  logic [23:0]       s2_prev_q;
  logic [SUM_W-1:0]  s2_r_q, s2_g_q, s2_b_q;
  logic [SUM_W-1:0]  s2_r_d, s2_g_d, s2_b_d;

  logic [7:0]        c_r, c_g, c_b;
  logic [SUM_W-1:0]  acc_r, acc_g, acc_b;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic [7:0]        avg_r, avg_g, avg_b;

  assign advance    = !s2_valid_q || !full_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;
  assign op         = ppdr_pkg::op_e'(operation_i);
  assign pal_wr     = accept && (op == ppdr_pkg::OP_PAL_WRITE);
  assign pal_rd     = accept && ((op == ppdr_pkg::OP_PIXEL) ||
                                 ((op == ppdr_pkg::OP_SAMPLE) && cfg_i.detail_enable));

  assign wr_slot = ppdr_pkg::slot_mod(palette_slot_i, PALETTE_ENTRIES);
  assign rd_slot = ppdr_pkg::slot_mod(color_index_i, PALETTE_ENTRIES);

  ppdr_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_wr),
    .waddr_i (wr_slot[AW-1:0]),
    .wdata_i ({blue_in_i, green_in_i, red_in_i}),
    .re_i    (pal_rd),
    .raddr_i (rd_slot[AW-1:0]),
    .rdata_o (rdata)
  );

  assign c_r     = ppdr_pkg::expand6(rdata[7:0],   cfg_i.expand_six_bit);
  assign c_g     = ppdr_pkg::expand6(rdata[15:8],  cfg_i.expand_six_bit);
  assign c_b     = ppdr_pkg::expand6(rdata[23:16], cfg_i.expand_six_bit);
  assign acc_r   = sum_r_q + SUM_W'(c_r);
  assign acc_g   = sum_g_q + SUM_W'(c_g);
  assign acc_b   = sum_b_q + SUM_W'(c_b);
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    cnt_d      = cnt_q;
    sum_r_d    = sum_r_q;
    sum_g_d    = sum_g_q;
    sum_b_d    = sum_b_q;
    s2_valid_d = s2_valid_q;
    s2_tile_d  = s2_tile_q;
    s2_r_d     = s2_r_q;
    s2_g_d     = s2_g_q;
    s2_b_d     = s2_b_q;
    if (advance) begin
      s2_valid_d = 1'b0;
      if (s1_valid_q) begin
        if (!s1_tile_q) begin
          // plain pixel drops any partial tile
          s2_valid_d = 1'b1;
          s2_tile_d  = 1'b0;
          s2_r_d     = SUM_W'(c_r);
          s2_g_d     = SUM_W'(c_g);
          s2_b_d     = SUM_W'(c_b);
          cnt_d      = '0;
          sum_r_d    = '0;
          sum_g_d    = '0;
          sum_b_d    = '0;
        end else if (cnt_inc == CNT_W'(TOTAL)) begin
          s2_valid_d = 1'b1;
          s2_tile_d  = 1'b1;
          s2_r_d     = acc_r + SUM_W'(HALF);
          s2_g_d     = acc_g + SUM_W'(HALF);
          s2_b_d     = acc_b + SUM_W'(HALF);
          cnt_d      = '0;
          sum_r_d    = '0;
          sum_g_d    = '0;
          sum_b_d    = '0;
        end else begin
          cnt_d   = cnt_inc;
          sum_r_d = acc_r;
          sum_g_d = acc_g;
          sum_b_d = acc_b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      cnt_q      <= '0;
      sum_r_q    <= '0;
      sum_g_q    <= '0;
      sum_b_q    <= '0;
    end else begin
      if (advance) begin
        s1_valid_q <= pal_rd;
      end
      s2_valid_q <= s2_valid_d;
      cnt_q      <= cnt_d;
      sum_r_q    <= sum_r_d;
      sum_g_q    <= sum_g_d;
      sum_b_q    <= sum_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_tile_q <= (op == ppdr_pkg::OP_SAMPLE);
      s1_prev_q <= previous_rgb_i;
      s2_prev_q <= s1_prev_q;
    end
    s2_tile_q <= s2_tile_d;
    s2_r_q    <= s2_r_d;
    s2_g_q    <= s2_g_d;
    s2_b_q    <= s2_b_d;
  end

  // rounded mean through the constant reciprocal
  assign prod_r = PROD_W'(s2_r_q) * PROD_W'(RECIP);
  assign prod_g = PROD_W'(s2_g_q) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(s2_b_q) * PROD_W'(RECIP);
  assign avg_r  = prod_r[SHIFT +: 8];
  assign avg_g  = prod_g[SHIFT +: 8];
  assign avg_b  = prod_b[SHIFT +: 8];

  assign push_o            = s2_valid_q && !full_i;
  assign push_data_o.prev  = s2_prev_q;
  assign push_data_o.color = s2_tile_q ? {avg_b, avg_g, avg_r}
                                       : {s2_b_q[7:0], s2_g_q[7:0], s2_r_q[7:0]};

endmodule

// ===== hw/rtl/ppdr_back.sv =====
// Back end: compare, raster position, dirty span and rectangle, result beats.
module ppdr_back #(
  parameter int MAX_DIMENSION = ppdr_pkg::MAX_DIMENSION_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ppdr_pkg::cfg_t  cfg_i,
  input  logic            task_valid_i,
  input  ppdr_pkg::task_t task_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ppdr_pkg::res_t  res_o
);

  localparam int DW    = ppdr_pkg::DIM_W;
  localparam int POS_W = $clog2(MAX_DIMENSION);

  logic [DW-1:0]    w, h, w_grp, x_ext, y_ext;
  logic [POS_W-1:0] x_q, x_d, y_q, y_d;
  logic             gd_q, gd_d;
  logic [DW-1:0]    rl_q, rl_d, rr_q, rr_d;
  logic [DW-1:0]    bl_q, bt_q, br_q, bb_q;
  logic [DW-1:0]    bl_d, bt_d, br_d, bb_d;
  logic             changed, frame_end;
  logic             span_hit;
  logic [DW-1:0]    span_lo, span_hi;
  ppdr_pkg::res_t   pix_res, rect_res;
  ppdr_pkg::res_t   res_q, rect_q;
  logic             out_valid_q, rect_pend_q;
  logic             load;

  function automatic logic [DW-1:0] clamp_dim(logic [DW-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end
    if (v > DW'(MAX_DIMENSION)) begin
      return DW'(MAX_DIMENSION);
    end
    return v;
  endfunction

  assign w     = clamp_dim(cfg_i.frame_width);
  assign h     = clamp_dim(cfg_i.frame_height);
  assign w_grp = {w[DW-1:2], 2'b00};
  assign x_ext = DW'(x_q);
  assign y_ext = DW'(y_q);

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = task_valid_i && load && !rect_pend_q;

  always_comb begin
    changed   = cfg_i.compare_enable ? (task_i.color != task_i.prev) : 1'b1;
    gd_d      = gd_q;
    rl_d      = rl_q;
    rr_d      = rr_q;
    bl_d      = bl_q;
    bt_d      = bt_q;
    br_d      = br_q;
    bb_d      = bb_q;
    x_d       = x_q;
    y_d       = y_q;
    frame_end = 1'b0;
    span_hit  = 1'b0;
    span_lo   = x_ext;
    span_hi   = x_ext + 1'b1;

    if (cfg_i.compare_enable) begin
      if (x_ext < w_grp) begin
        if (changed) begin
          gd_d = 1'b1;
        end
        if (x_q[1:0] == 2'b11) begin
          span_hit = gd_d;
          span_lo  = x_ext - DW'(3);
          gd_d     = 1'b0;
        end
      end else begin
        span_hit = changed;
      end
    end
    if (span_hit) begin
      if (rr_d == '0) begin
        rl_d = span_lo;
      end
      rr_d = span_hi;
    end

    if (x_ext + 1'b1 >= w) begin
      if (cfg_i.compare_enable && (rr_d != '0)) begin
        if (br_d == '0) begin
          bl_d = rl_d;
          bt_d = y_ext;
        end else if (rl_d < bl_d) begin
          bl_d = rl_d;
        end
        if (rr_d > br_d) begin
          br_d = rr_d;
        end
        bb_d = y_ext + 1'b1;
      end
      rl_d = '0;
      rr_d = '0;
      gd_d = 1'b0;
      x_d  = '0;
      if (y_ext + 1'b1 >= h) begin
        frame_end = 1'b1;
        y_d       = '0;
      end else begin
        y_d = y_q + 1'b1;
      end
    end else begin
      x_d = x_q + 1'b1;
    end

    pix_res         = '0;
    pix_res.kind    = ppdr_pkg::KIND_PIXEL;
    pix_res.red     = task_i.color[7:0];
    pix_res.green   = task_i.color[15:8];
    pix_res.blue    = task_i.color[23:16];
    pix_res.changed = changed;

    rect_res      = '0;
    rect_res.kind = ppdr_pkg::KIND_RECT;
    rect_res.last = 1'b1;
    if (!cfg_i.compare_enable) begin
      rect_res.right  = w;
      rect_res.bottom = h;
    end else if (br_d != '0) begin
      rect_res.left   = bl_d;
      rect_res.top    = bt_d;
      rect_res.right  = br_d;
      rect_res.bottom = bb_d;
    end else begin
      rect_res.empty = 1'b1;
    end

    if (frame_end) begin
      bl_d = '0;
      bt_d = '0;
      br_d = '0;
      bb_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      gd_q        <= 1'b0;
      rl_q        <= '0;
      rr_q        <= '0;
      bl_q        <= '0;
      bt_q        <= '0;
      br_q        <= '0;
      bb_q        <= '0;
      out_valid_q <= 1'b0;
      rect_pend_q <= 1'b0;
    end else begin
      if (pop_o) begin
        x_q  <= x_d;
        y_q  <= y_d;
        gd_q <= gd_d;
        rl_q <= rl_d;
        rr_q <= rr_d;
        bl_q <= bl_d;
        bt_q <= bt_d;
        br_q <= br_d;
        bb_q <= bb_d;
      end
      if (load) begin
        if (rect_pend_q) begin
          out_valid_q <= 1'b1;
          rect_pend_q <= 1'b0;
        end else if (pop_o) begin
          out_valid_q <= 1'b1;
          rect_pend_q <= frame_end;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (rect_pend_q) begin
        res_q <= rect_q;
      end else if (pop_o) begin
        res_q  <= pix_res;
        rect_q <= rect_res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/palette_pixel_dirty_rect.sv =====
// Top level: palette lookup of indexed pixels with dirty rectangle tracking.
//
//  channel | direction | handshake                | beat carries
//  --------+-----------+--------------------------+-----------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | register index, write data
//  in      | in        | in_valid_i / in_ready_o   | operation, slot, color, index, prev
//  out     | out       | out_valid_o / out_ready_i | kind, rgb, changed, rect, empty, last
//
// One input beat per clock sustained while the queue has room. A pixel passes the
// palette RAM read, expand/accumulate, rounded mean into the queue and back end
// into the output register. The last pixel of a frame is followed by a rectangle
// beat, sent before the next color is popped. Reset clears all control state;
// palette contents stay undefined until written. Input and output stall
// independently through the four-entry queue between front and back.
module palette_pixel_dirty_rect #(
  parameter int SUBPIXEL_SCALE  = ppdr_pkg::SUBPIXEL_SCALE_DEF,
  parameter int MAX_DIMENSION   = ppdr_pkg::MAX_DIMENSION_DEF,
  parameter int PALETTE_ENTRIES = ppdr_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      operation_i,
  input  logic [7:0]                      palette_slot_i,
  input  logic [7:0]                      red_in_i,
  input  logic [7:0]                      green_in_i,
  input  logic [7:0]                      blue_in_i,
  input  logic [7:0]                      color_index_i,
  input  logic [23:0]                     previous_rgb_i,
  // result beats
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [7:0]                      red_out_o,
  output logic [7:0]                      green_out_o,
  output logic [7:0]                      blue_out_o,
  output logic                            pixel_changed_o,
  output logic [ppdr_pkg::DIM_W-1:0]      rect_left_o,
  output logic [ppdr_pkg::DIM_W-1:0]      rect_top_o,
  output logic [ppdr_pkg::DIM_W-1:0]      rect_right_o,
  output logic [ppdr_pkg::DIM_W-1:0]      rect_bottom_o,
  output logic                            rect_empty_o,
  output logic                            last_o
);

  ppdr_pkg::cfg_t  cfg_q;
  ppdr_pkg::task_t push_data, pop_data;
  ppdr_pkg::res_t  res;
  logic            push, full, pop, task_valid;

  // config registers; writes land any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= ppdr_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height   <= ppdr_pkg::FRAME_HEIGHT_RST;
      cfg_q.expand_six_bit <= 1'b0;
      cfg_q.compare_enable <= 1'b0;
      cfg_q.detail_enable  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ppdr_pkg::cfg_idx_e'(cfg_index_i))
        ppdr_pkg::CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i;
        ppdr_pkg::CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i;
        ppdr_pkg::CFG_EXPAND_SIX_BIT: cfg_q.expand_six_bit <= cfg_data_i[0];
        ppdr_pkg::CFG_COMPARE_ENABLE: cfg_q.compare_enable <= cfg_data_i[0];
        ppdr_pkg::CFG_DETAIL_ENABLE:  cfg_q.detail_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front: palette writes, lookups, tile averaging
  ppdr_front #(
    .SUBPIXEL_SCALE  (SUBPIXEL_SCALE),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .palette_slot_i (palette_slot_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .color_index_i  (color_index_i),
    .previous_rgb_i (previous_rgb_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  // decoupling queue of finished colors
  ppdr_fifo #(
    .DEPTH (ppdr_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (task_valid),
    .pop_data_o  (pop_data)
  );

  // back: compare, raster walk, dirty rectangle, output register
  ppdr_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .task_valid_i (task_valid),
    .task_i       (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign result_kind_o   = res.kind;
  assign red_out_o       = res.red;
  assign green_out_o     = res.green;
  assign blue_out_o      = res.blue;
  assign pixel_changed_o = res.changed;
  assign rect_left_o     = res.left;
  assign rect_top_o      = res.top;
  assign rect_right_o    = res.right;
  assign rect_bottom_o   = res.bottom;
  assign rect_empty_o    = res.empty;
  assign last_o          = res.last;

endmodule

// ===== tb/sv/palette_rect_checker.sv =====
`timescale 1ns / 100ps
// Checker for the palette pixel dirty-rect block: predicts every result beat and compares.
module palette_rect_checker
  import ppdr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            operation_i,
  input  logic [7:0]            palette_slot_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic [7:0]            color_index_i,
  input  logic [23:0]           previous_rgb_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  result_kind_i,
  input  logic [7:0]            red_out_i,
  input  logic [7:0]            green_out_i,
  input  logic [7:0]            blue_out_i,
  input  logic                  pixel_changed_i,
  input  logic [DIM_W-1:0]      rect_left_i,
  input  logic [DIM_W-1:0]      rect_top_i,
  input  logic [DIM_W-1:0]      rect_right_i,
  input  logic [DIM_W-1:0]      rect_bottom_i,
  input  logic                  rect_empty_i,
  input  logic                  last_i,
  output int unsigned           beats_pending_o,
  output int unsigned           mismatches_o
);

  localparam int unsigned TILE_SAMPLES = SUBPIXEL_SCALE_DEF * SUBPIXEL_SCALE_DEF;
  localparam int unsigned REPORT_CAP   = 100;

  logic [23:0]      palette_mem [PALETTE_ENTRIES_DEF];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             expand_reg;
  logic             compare_reg;
  logic             detail_reg;

  int unsigned col_pos, row_pos;
  int unsigned tile_count, red_acc, green_acc, blue_acc;
  logic        group_hit;
  int unsigned span_lo, span_hi;
  int unsigned box_left, box_top, box_right, box_bottom;
  res_t        expected_beats [$];
  int unsigned mismatch_total = 0;

  function automatic int unsigned fit_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return v;
  endfunction

  function automatic logic [7:0] widen6(logic [7:0] c);
    return expand_reg ? ((c & 8'hFC) | (c >> 6)) : c;
  endfunction

  function automatic logic [23:0] palette_color(logic [7:0] idx);
    logic [23:0] raw;
    raw = palette_mem[idx];
    return {widen6(raw[23:16]), widen6(raw[15:8]), widen6(raw[7:0])};
  endfunction

  // span_hi of zero means no span yet, so the first mark sets the left edge
  function automatic void widen_row_span(int unsigned lo, int unsigned hi);
    if (span_hi == 0) span_lo = lo;
    span_hi = hi;
  endfunction

  function automatic void emit_pixel(logic [23:0] color, logic [23:0] prev);
    int unsigned w, h, x, y;
    logic        changed;
    res_t        px, rect;
    w = fit_dim(width_reg);
    h = fit_dim(height_reg);
    x = col_pos;
    y = row_pos;
    changed = compare_reg ? (color != prev) : 1'b1;
    px = '0;
    px.kind    = KIND_PIXEL;
    px.red     = color[7:0];
    px.green   = color[15:8];
    px.blue    = color[23:16];
    px.changed = changed;
    expected_beats.insert(expected_beats.size(), px);

    if (compare_reg) begin
      if (x < (w & 32'hFFFF_FFFC)) begin
        if (changed) group_hit = 1'b1;
        if ((x % 4) == 3) begin
          if (group_hit) widen_row_span(x - 3, x + 1);
          group_hit = 1'b0;
        end
      end else if (changed) begin
        widen_row_span(x, x + 1);
      end
    end

    if (x + 1 >= w) begin
      if (compare_reg && span_hi != 0) begin
        if (box_right == 0) begin
          box_left = span_lo;
          box_top  = y;
        end else if (span_lo < box_left) begin
          box_left = span_lo;
        end
        if (span_hi > box_right) box_right = span_hi;
        box_bottom = y + 1;
      end
      span_lo   = 0;
      span_hi   = 0;
      group_hit = 1'b0;
      col_pos   = 0;
      if (y + 1 >= h) begin
        rect = '0;
        rect.kind = KIND_RECT;
        rect.last = 1'b1;
        if (!compare_reg) begin
          rect.right  = DIM_W'(w);
          rect.bottom = DIM_W'(h);
        end else if (box_right != 0) begin
          rect.left   = DIM_W'(box_left);
          rect.top    = DIM_W'(box_top);
          rect.right  = DIM_W'(box_right);
          rect.bottom = DIM_W'(box_bottom);
        end else begin
          rect.empty = 1'b1;
        end
        expected_beats.insert(expected_beats.size(), rect);
        box_left   = 0;
        box_top    = 0;
        box_right  = 0;
        box_bottom = 0;
        row_pos    = 0;
      end else begin
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic void clear_tile();
    tile_count = 0;
    red_acc    = 0;
    green_acc  = 0;
    blue_acc   = 0;
  endfunction

  function automatic void predict_input();
    logic [23:0] c;
    case (operation_i)
      OP_PAL_WRITE: palette_mem[palette_slot_i] = {blue_in_i, green_in_i, red_in_i};
      OP_PIXEL: begin
        clear_tile();
        emit_pixel(palette_color(color_index_i), previous_rgb_i);
      end
      OP_SAMPLE: begin
        // samples are dropped silently while detail mode is off
        if (detail_reg) begin
          c = palette_color(color_index_i);
          red_acc   += c[7:0];
          green_acc += c[15:8];
          blue_acc  += c[23:16];
          tile_count++;
          if (tile_count == TILE_SAMPLES) begin
            c = {8'((blue_acc + TILE_SAMPLES / 2) / TILE_SAMPLES),
                 8'((green_acc + TILE_SAMPLES / 2) / TILE_SAMPLES),
                 8'((red_acc + TILE_SAMPLES / 2) / TILE_SAMPLES)};
            clear_tile();
            emit_pixel(c, previous_rgb_i);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      width_reg   = FRAME_WIDTH_RST;
      height_reg  = FRAME_HEIGHT_RST;
      expand_reg  = 1'b0;
      compare_reg = 1'b0;
      detail_reg  = 1'b0;
      col_pos     = 0;
      row_pos     = 0;
      clear_tile();
      group_hit   = 1'b0;
      span_lo     = 0;
      span_hi     = 0;
      box_left    = 0;
      box_top     = 0;
      box_right   = 0;
      box_bottom  = 0;
      expected_beats.delete();
      beats_pending_o <= 0;
      mismatches_o    <= 0;
    end else begin
      // result side first, so a beat in the same cycle cannot hide a stray result
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_CAP)
            $display("%0t: result beat with none expected, expected none actual kind %0h",
                     $time, result_kind_i);
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind", want.kind, result_kind_i);
          check_field("red_out", want.red, red_out_i);
          check_field("green_out", want.green, green_out_i);
          check_field("blue_out", want.blue, blue_out_i);
          check_field("pixel_changed", want.changed, pixel_changed_i);
          check_field("rect_left", want.left, rect_left_i);
          check_field("rect_top", want.top, rect_top_i);
          check_field("rect_right", want.right, rect_right_i);
          check_field("rect_bottom", want.bottom, rect_bottom_i);
          check_field("rect_empty", want.empty, rect_empty_i);
          check_field("last", want.last, last_i);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:    width_reg   = cfg_data_i;
          CFG_FRAME_HEIGHT:   height_reg  = cfg_data_i;
          CFG_EXPAND_SIX_BIT: expand_reg  = cfg_data_i[0];
          CFG_COMPARE_ENABLE: compare_reg = cfg_data_i[0];
          CFG_DETAIL_ENABLE:  detail_reg  = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) predict_input();

      beats_pending_o <= expected_beats.size();
      mismatches_o    <= mismatch_total;
    end
  end

endmodule

// ===== tb/sv/tb_palette_pixel_dirty_rect.sv =====
`timescale 1ns / 100ps
// Testbench top for the palette pixel dirty-rect block: stimulus, idling and verdict.
module tb_palette_pixel_dirty_rect;
  import ppdr_pkg::*;

  localparam logic [1:0]  OP_RESERVED   = 2'd3;   // unused operation code, must be ignored
  localparam int unsigned TILE_SAMPLES  = SUBPIXEL_SCALE_DEF * SUBPIXEL_SCALE_DEF;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_BEATS   = 150;    // ten phases, ~1550 beats with directed ones
  localparam int unsigned STEADY_PHASE  = 7;      // no idling on either side here
  localparam int unsigned IDLE_PCT      = 33;
  localparam int unsigned SETTLE_CYCLES = 12;     // pipeline is four stages deep, give it margin
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Phase plan: geometry extremes (0 and 16383 clamp, 8192 max) mixed with small
  // frames so that rows and frames close often. Geometry also changes mid-frame.
  int unsigned plan_width  [NUM_PHASES] = '{4, 7, 1, 0, 16383, 8192, 13, 9, 2, 3};
  int unsigned plan_height [NUM_PHASES] = '{3, 2, 5, 0, 16383, 1, 3, 4, 2, 6};
  bit          plan_expand [NUM_PHASES] = '{0, 1, 0, 1, 0, 0, 0, 1, 0, 0};
  bit          plan_compare[NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1, 0, 1};
  bit          plan_detail [NUM_PHASES] = '{0, 1, 1, 1, 0, 1, 1, 1, 0, 1};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            operation = '0;
  logic [7:0]            palette_slot = '0;
  logic [7:0]            red_in = '0;
  logic [7:0]            green_in = '0;
  logic [7:0]            blue_in = '0;
  logic [7:0]            color_index = '0;
  logic [23:0]           previous_rgb = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  result_kind;
  logic [7:0]            red_out, green_out, blue_out;
  logic                  pixel_changed;
  logic [DIM_W-1:0]      rect_left, rect_top, rect_right, rect_bottom;
  logic                  rect_empty;
  logic                  last;

  int unsigned beats_pending;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  bit          steady = 1'b0;
  bit          detail_on = 1'b0;

  // stimulus-side knowledge of the palette: which slots hold a color, and which
  logic [23:0] pal_shadow [256];
  bit          slot_loaded [256];

  always #5 clk = ~clk;

  palette_pixel_dirty_rect DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .palette_slot_i (palette_slot),
    .red_in_i       (red_in),
    .green_in_i     (green_in),
    .blue_in_i      (blue_in),
    .color_index_i  (color_index),
    .previous_rgb_i (previous_rgb),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .red_out_o      (red_out),
    .green_out_o    (green_out),
    .blue_out_o     (blue_out),
    .pixel_changed_o(pixel_changed),
    .rect_left_o    (rect_left),
    .rect_top_o     (rect_top),
    .rect_right_o   (rect_right),
    .rect_bottom_o  (rect_bottom),
    .rect_empty_o   (rect_empty),
    .last_o         (last)
  );

  palette_rect_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .operation_i    (operation),
    .palette_slot_i (palette_slot),
    .red_in_i       (red_in),
    .green_in_i     (green_in),
    .blue_in_i      (blue_in),
    .color_index_i  (color_index),
    .previous_rgb_i (previous_rgb),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .red_out_i      (red_out),
    .green_out_i    (green_out),
    .blue_out_i     (blue_out),
    .pixel_changed_i(pixel_changed),
    .rect_left_i    (rect_left),
    .rect_top_i     (rect_top),
    .rect_right_i   (rect_right),
    .rect_bottom_i  (rect_bottom),
    .rect_empty_i   (rect_empty),
    .last_i         (last),
    .beats_pending_o(beats_pending),
    .mismatches_o   (mismatch_count)
  );

  // Result side: back-pressure about a third of the cycles, none in the steady phase.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Valid is held until the beat goes through. Per-cycle idle draws put gaps
  // before any beat, tile samples and palette writes included.
  task automatic send_beat(logic [1:0] op, logic [7:0] slot, logic [23:0] rgb,
                           logic [7:0] idx, logic [23:0] prev);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    palette_slot <= slot;
    red_in       <= rgb[7:0];
    green_in     <= rgb[15:8];
    blue_in      <= rgb[23:16];
    color_index  <= idx;
    previous_rgb <= prev;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Config beats go back to back; valid drops once after the last one.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Single-bit registers get random upper data bits, which must not matter.
  task automatic program_setup(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               bit expand, bit compare, bit detail);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_EXPAND_SIX_BIT, {13'($urandom), expand});
    write_reg(CFG_COMPARE_ENABLE, {13'($urandom), compare});
    write_reg(CFG_DETAIL_ENABLE, {13'($urandom), detail});
    cfg_valid <= 1'b0;
    detail_on = detail;
  endtask

  // Hold off the sender until every predicted result is out, then let beats
  // that cause no result (writes, partial tiles) clear the pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_palette(logic [7:0] slot, logic [23:0] rgb);
    send_beat(OP_PAL_WRITE, slot, rgb, 8'($urandom), 24'($urandom));
    pal_shadow[slot]  = rgb;
    slot_loaded[slot] = 1'b1;
  endtask

  // Random index; an unloaded slot is written first so no read hits a blank entry.
  task automatic ready_index(output logic [7:0] idx);
    idx = 8'($urandom);
    if (!slot_loaded[idx]) write_palette(idx, 24'($urandom));
  endtask

  // Quiet stretches reuse the stored color; unexpanded, unmixed pixels then compare equal.
  function automatic logic [23:0] pick_prev(logic [7:0] idx, bit quiet);
    if (quiet || $urandom_range(1) == 1) return pal_shadow[idx];
    return 24'($urandom);
  endfunction

  task automatic send_pixel(logic [7:0] idx, logic [23:0] prev);
    send_beat(OP_PIXEL, 8'($urandom), 24'($urandom), idx, prev);
  endtask

  task automatic send_sample(logic [7:0] idx, logic [23:0] prev);
    send_beat(OP_SAMPLE, 8'($urandom), 24'($urandom), idx, prev);
  endtask

  // Mostly one index per tile so the average equals the entry; some tiles mix.
  // Palette writes land inside tiles now and then.
  task automatic send_tile(int unsigned count, bit quiet);
    logic [7:0]  base;
    logic [7:0]  idx;
    logic [23:0] prev;
    bit          mixed;
    mixed = ($urandom_range(3) == 0);
    ready_index(base);
    prev = pick_prev(base, quiet);
    for (int unsigned k = 0; k < count; k++) begin
      idx = base;
      if (mixed) ready_index(idx);
      if ($urandom_range(19) == 0) write_palette(8'($urandom), 24'($urandom));
      send_sample(idx, prev);
    end
  endtask

  // Every accepted beat counts toward the phase budget.
  task automatic run_phase(int unsigned beats);
    int unsigned start;
    int unsigned pick;
    int unsigned burst;
    bit          quiet;
    logic [7:0]  idx;
    start = beats_sent;
    burst = 0;
    quiet = 1'b0;
    while (beats_sent - start < beats) begin
      // bursts pick at random between all-unchanged content and mixed content,
      // so whole frames come out clean often enough to see an empty rectangle
      if (burst == 0) begin
        burst = $urandom_range(24, 1);
        quiet = ($urandom_range(9) < 4);
      end
      burst--;
      pick = $urandom_range(99);
      if (detail_on && pick < 30) begin
        if ($urandom_range(9) == 0) begin
          // short tile: the next pixel drops it, or the next tile absorbs it
          send_tile($urandom_range(TILE_SAMPLES - 1, 1), quiet);
        end else begin
          send_tile(TILE_SAMPLES, quiet);
        end
      end else if (pick < 85) begin
        ready_index(idx);
        send_pixel(idx, pick_prev(idx, quiet));
      end else if (pick < 93) begin
        write_palette(8'($urandom), 24'($urandom));
      end else if (pick < 96) begin
        send_beat(OP_RESERVED, 8'($urandom), 24'($urandom), 8'($urandom), 24'($urandom));
      end else begin
        ready_index(idx);
        send_sample(idx, 24'($urandom));
      end
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame: 5 wide (one group of four plus a tail pixel), 2 rows.
    program_setup(14'd5, 14'd2, 1'b0, 1'b1, 1'b1);
    write_palette(8'h00, 24'h000000);
    write_palette(8'hFF, 24'hFFFFFF);
    write_palette(8'h55, 24'h123456);
    write_palette(8'hAA, 24'hC08143);
    send_beat(OP_RESERVED, 8'hFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF);
    // row 0: group hit by two changed pixels, unchanged tail
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'hFF, 24'h000000);
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'hAA, 24'hFFFFFF);
    send_pixel(8'h55, 24'h123456);
    // row 1: partial tile, palette write inside it, then a pixel drops the tile
    send_sample(8'hFF, 24'h000000);
    send_sample(8'hFF, 24'h000000);
    write_palette(8'h55, 24'h00FF00);
    send_pixel(8'h55, 24'hFFFFFF);
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'hFF, 24'hFFFFFF);
    drain_results();

    // 1x1 frames with six-bit expansion: ignored sample, clean frame, dirty frame.
    // Height 0 reads as 1.
    program_setup(14'd1, 14'd0, 1'b1, 1'b1, 1'b0);
    send_sample(8'h00, 24'h000000);
    send_pixel(8'hAA, 24'hC38241);
    send_pixel(8'hFF, 24'h000000);
    drain_results();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      program_setup(DIM_W'(plan_width[p]), DIM_W'(plan_height[p]),
                    plan_expand[p], plan_compare[p], plan_detail[p]);
      steady = (p == STEADY_PHASE);
      run_phase(PHASE_BEATS);
      drain_results();
      steady = 1'b0;
    end

    if (mismatch_count == 0 && beats_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
